[design/gpal_pkg.sv]
// package for the gpib address line parser
// holds the parse phase type and the address range constants; no dependencies
package gpal_pkg;

    typedef enum logic [2:0] {
        PH_LEAD   = 3'd0,
        PH_PRI    = 3'd1,
        PH_SEP    = 3'd2,
        PH_SEC    = 3'd3,
        PH_TAIL_P = 3'd4,
        PH_TAIL_S = 3'd5,
        PH_ERR    = 3'd6
    } t_phase;

    localparam int unsigned CHAR_W = 8;
    localparam int unsigned PRI_W  = 5;
    localparam int unsigned SEC_W  = 7;

    localparam logic [PRI_W-1:0] PRI_MAX = 5'd30;
    localparam logic [SEC_W-1:0] SEC_MIN = 7'd96;
    localparam logic [SEC_W-1:0] SEC_MAX = 7'd126;
    localparam logic [PRI_W-1:0] PRI_SAT = 5'd31;
    localparam logic [SEC_W-1:0] SEC_SAT = 7'd127;

    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

endpackage

[design/gpib_address_line_parser_unit.sv]
// gpib address line parser: one ascii byte per beat, one result beat per line
// depends on gpal_pkg for the phase type and range constants
//
// datapath: an accepted byte is held in the input register and parsed from there
//   into the phase and accumulators; a line-end byte's result beat is registered
// throughput: one byte per cycle, set by the phase update and times-ten
//   accumulate; only a line-end byte waits, while the result is stalled
// reset: synchronous active-low i_rst_n clears both valid flags, the phase
//   (back to leading spaces) and the two accumulators
module gpib_address_line_parser_unit
    import gpal_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // byte channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [CHAR_W-1:0]  i_char_in,
    input  logic               i_line_end,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_valid_res,
    output logic [PRI_W-1:0]   o_primary_addr,
    output logic               o_has_secondary,
    output logic [SEC_W-1:0]   o_secondary_addr
);

    // input register
    logic              r_in_vld;
    logic [CHAR_W-1:0] r_in_char;
    logic              r_in_end;

    // parse state
    t_phase            r_phase,   n_phase;
    logic [PRI_W-1:0]  r_pri_acc, n_pri_acc;
    logic [SEC_W-1:0]  r_sec_acc, n_sec_acc;

    // result register
    logic              r_out_vld;
    logic              r_res_ok,  n_res_ok;
    logic [PRI_W-1:0]  r_res_pri, n_res_pri;
    logic              r_res_sec, n_res_sec;
    logic [SEC_W-1:0]  r_res_sad, n_res_sad;

    logic proc_go;   // the held byte is parsed this cycle
    logic in_acc;    // a byte beat is taken this cycle

    // character classes of the held byte
    logic       is_dig, is_sp, is_eol;
    logic [3:0] dig_val;

    // accumulate datapath: acc * 10 + digit, saturating
    logic [PRI_W-1:0] pri_base;
    logic [SEC_W-1:0] sec_base;
    logic [8:0]       pri_sum;
    logic [10:0]      sec_sum;
    logic [PRI_W-1:0] pri_next;
    logic [SEC_W-1:0] sec_next;

    // a line-end byte can only move on when the result slot is free or draining
    assign proc_go    = r_in_vld && (!r_in_end || !r_out_vld || !i_out_stall);
    assign o_in_stall = r_in_vld && !proc_go;
    assign in_acc     = i_in_valid && !o_in_stall;

    assign is_dig  = (r_in_char >= CH_ZERO) && (r_in_char <= CH_NINE);
    assign is_sp   = (r_in_char == CH_SPACE);
    assign is_eol  = (r_in_char == CH_CR) || (r_in_char == CH_LF);
    // ascii digits keep their value in the low nibble
    assign dig_val = r_in_char[3:0];

    // the first digit of a number starts from zero
    assign pri_base = (r_phase == PH_LEAD) ? '0 : r_pri_acc;
    assign sec_base = (r_phase == PH_SEP)  ? '0 : r_sec_acc;
    assign pri_sum  = ({4'd0, pri_base} * 9'd10) + {5'd0, dig_val};
    assign sec_sum  = ({4'd0, sec_base} * 11'd10) + {7'd0, dig_val};
    assign pri_next = (pri_sum > {4'd0, PRI_SAT}) ? PRI_SAT : pri_sum[PRI_W-1:0];
    assign sec_next = (sec_sum > {4'd0, SEC_SAT}) ? SEC_SAT : sec_sum[SEC_W-1:0];

    // next phase, accumulators and the result of a line-end byte
    always_comb begin
        n_phase   = r_phase;
        n_pri_acc = r_pri_acc;
        n_sec_acc = r_sec_acc;

        unique case (r_phase) inside
            PH_LEAD: begin
                if (is_dig) begin
                    n_pri_acc = pri_next;
                    n_phase   = PH_PRI;
                end else if (!is_sp) begin
                    n_phase = PH_ERR;
                end
            end
            PH_PRI: begin
                if (is_dig) begin
                    n_pri_acc = pri_next;
                end else if (is_sp) begin
                    n_phase = PH_SEP;
                end else if (is_eol) begin
                    n_phase = PH_TAIL_P;
                end else begin
                    n_phase = PH_ERR;
                end
            end
            PH_SEP: begin
                if (is_dig) begin
                    n_sec_acc = sec_next;
                    n_phase   = PH_SEC;
                end else if (is_eol) begin
                    n_phase = PH_TAIL_P;
                end else if (!is_sp) begin
                    n_phase = PH_ERR;
                end
            end
            PH_SEC: begin
                if (is_dig) begin
                    n_sec_acc = sec_next;
                end else if (is_sp || is_eol) begin
                    n_phase = PH_TAIL_S;
                end else begin
                    n_phase = PH_ERR;
                end
            end
            PH_TAIL_P, PH_TAIL_S: begin
                if (!(is_sp || is_eol)) begin
                    n_phase = PH_ERR;
                end
            end
            default: begin
                n_phase = PH_ERR;
            end
        endcase

        // judge the line from the state after this byte
        n_res_ok  = 1'b0;
        n_res_sec = 1'b0;
        unique case (n_phase) inside
            PH_PRI, PH_SEP, PH_TAIL_P: begin
                n_res_ok = (n_pri_acc <= PRI_MAX);
            end
            PH_SEC, PH_TAIL_S: begin
                n_res_sec = 1'b1;
                n_res_ok  = (n_pri_acc <= PRI_MAX) &&
                            (n_sec_acc >= SEC_MIN) && (n_sec_acc <= SEC_MAX);
            end
            default: begin
                n_res_ok = 1'b0;
            end
        endcase
        n_res_pri = n_res_ok ? n_pri_acc : '0;
        n_res_sad = (n_res_ok && n_res_sec) ? n_sec_acc : '0;
        n_res_sec = n_res_ok && n_res_sec;

        // a line end brings the parser back to its reset state
        if (r_in_end) begin
            n_phase   = PH_LEAD;
            n_pri_acc = '0;
            n_sec_acc = '0;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_acc) begin
            r_in_vld <= 1'b1;
        end else if (proc_go) begin
            r_in_vld <= 1'b0;
        end
        if (in_acc) begin
            r_in_char <= i_char_in;
            r_in_end  <= i_line_end;
        end
    end

    // parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_LEAD;
            r_pri_acc <= '0;
            r_sec_acc <= '0;
        end else if (proc_go) begin
            r_phase   <= n_phase;
            r_pri_acc <= n_pri_acc;
            r_sec_acc <= n_sec_acc;
        end
    end

    // result register, held while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (proc_go && r_in_end) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
        if (proc_go && r_in_end) begin
            r_res_ok  <= n_res_ok;
            r_res_pri <= n_res_pri;
            r_res_sec <= n_res_sec;
            r_res_sad <= n_res_sad;
        end
    end

    assign o_out_valid      = r_out_vld;
    assign o_valid_res      = r_res_ok;
    assign o_primary_addr   = r_res_pri;
    assign o_has_secondary  = r_res_sec;
    assign o_secondary_addr = r_res_sad;

    // a legal result carries an address in range
    a_pri_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_valid_res) |-> (o_primary_addr <= PRI_MAX))
        else $error("primary address out of range on a legal result");

    // a secondary that is reported lies in 96..126
    a_sec_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_has_secondary) |->
        (o_valid_res && (o_secondary_addr >= SEC_MIN) && (o_secondary_addr <= SEC_MAX)))
        else $error("secondary address out of range");

    // a rejected line reports all fields at zero
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_valid_res) |->
        ((o_primary_addr == '0) && !o_has_secondary && (o_secondary_addr == '0)))
        else $error("rejected line with nonzero fields");

    // parsing a line end returns the parser to leading spaces with clear sums
    a_line_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc_go && r_in_end) |=>
        ((r_phase == PH_LEAD) && (r_pri_acc == '0) && (r_sec_acc == '0)))
        else $error("parser not back in reset state after line end");

endmodule
